@@ sv/mmsm_pkg.sv @@
package mmsm_pkg;

   localparam int MACHINES_DEF = 8;
   localparam int TIME_W       = 48;
   localparam int IDX_W        = 3;
   localparam int RATIO_W      = 17;
   localparam int CSR_IDX_W    = 1;
   localparam int HALF_W       = TIME_W / 2;
   localparam int PART_W       = RATIO_W + HALF_W;
   localparam int PROD_W       = RATIO_W + TIME_W;

   localparam logic [RATIO_W-1:0] RATIO_ONE        = RATIO_W'(65536);
   localparam logic [RATIO_W-1:0] RATIO_LOW_RESET  = RATIO_W'(19661);
   localparam logic [RATIO_W-1:0] RATIO_HIGH_RESET = RATIO_W'(52429);

   localparam logic [CSR_IDX_W-1:0] REG_RATIO_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_RATIO_HIGH = CSR_IDX_W'(1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CAND = 1'b1;

   localparam logic MODE_MCT = 1'b0;
   localparam logic MODE_MET = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_PICK,
      ST_SCAN,
      ST_START,
      ST_RATIO,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] value;
   } wr_type;

   typedef struct packed {
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] hi;
   } scan_type;

   typedef struct packed {
      logic done;
      logic mode;
   } ratio_res_type;

endpackage

@@ sv/met_mct_switching_mapper.sv @@
// channel   ports                 handshake
// input     req_op .. req_last    req_valid / req_stall, taken when valid and not stall
// result    rsp_assigned_machine  rsp_valid / rsp_stall, taken when valid and not stall
//           .. rsp_no_machine
// config    csr_index, csr_wdata  csr_we, written at the edge
//
// a load that is not last stays in ST_IDLE, a candidate not last runs ST_CAND, ST_PICK
// a last load runs the min/max pass along the row of cells, then the ratio check;
// a last candidate runs the pick, the pass, the ratio check and ST_OUT
// a last candidate with no eligible machine skips the pass and goes to ST_OUT
// reset is synchronous; it zeroes all ready times, the mode and the running best
// a waiting result does not block the input; only a second result waits for the slot
module met_mct_switching_mapper
   import mmsm_pkg::*;
#(
   parameter int MACHINES = MACHINES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic [IDX_W-1:0]     req_machine_index,
   input  logic [TIME_W-1:0]    req_time_value,
   input  logic [TIME_W-1:0]    req_dep_ready,
   input  logic                 req_eligible,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IDX_W-1:0]     rsp_assigned_machine,
   output logic [TIME_W-1:0]    rsp_finish_time,
   output logic                 rsp_mode_after,
   output logic                 rsp_no_machine,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RATIO_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(MACHINES + 1);

   state_type          state_ff, state_in;
   logic [RATIO_W-1:0] rlow_ff, rhigh_ff;
   logic               mode_ff;
   logic [IDX_W-1:0]   best_machine_ff;
   logic [TIME_W-1:0]  best_complete_ff, best_exec_ff;
   logic               have_best_ff;
   logic [IDX_W-1:0]   c_idx_ff;
   logic [TIME_W-1:0]  c_tv_ff, c_dep_ff, c_done_ff;
   logic               c_ok_ff, c_last_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               res_pend_ff;
   logic [IDX_W-1:0]   res_machine_ff;
   logic [TIME_W-1:0]  res_finish_ff;
   logic               res_nom_ff;
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_machine_ff;
   logic [TIME_W-1:0]  rsp_finish_ff;
   logic               rsp_mode_ff, rsp_nom_ff;

   logic               accept, idx_ok, take, nb_have;
   logic [IDX_W-1:0]   nb_machine;
   logic [TIME_W-1:0]  nb_complete, nb_exec;
   logic [TIME_W-1:0]  rd_ready, start_t;
   logic [TIME_W:0]    sum_t;
   logic               scan_last, pick_close, out_load, ratio_start;
   wr_type             wr;
   ratio_res_type      rres;

   logic [TIME_W-1:0]  cell_ready [MACHINES];
   scan_type           chain [MACHINES+1];

   assign accept = req_valid && !req_stall;
   assign idx_ok = 32'(req_machine_index) < MACHINES;

   assign chain[0].lo = '1;
   assign chain[0].hi = '0;

   for (genvar i = 0; i < MACHINES; i++) begin : g_cell
      mmsm_cell #(.ID(i)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .wr     (wr),
         .scan_i (chain[i]),
         .ready  (cell_ready[i]),
         .scan_o (chain[i+1])
      );
   end

   mmsm_ratio u_ratio (
      .clock      (clock),
      .reset      (reset),
      .start      (ratio_start),
      .span       (chain[MACHINES]),
      .ratio_low  (rlow_ff),
      .ratio_high (rhigh_ff),
      .mode_cur   (mode_ff),
      .res        (rres)
   );

   always_comb begin
      rd_ready = '0;
      for (int i = 0; i < MACHINES; i++) begin
         if (32'(c_idx_ff) == i) begin
            rd_ready = cell_ready[i];
         end
      end
   end

   assign start_t = (c_dep_ff > rd_ready) ? c_dep_ff : rd_ready;
   assign sum_t   = {1'b0, start_t} + {1'b0, c_tv_ff};

   always_comb begin
      if (!have_best_ff) begin
         take = 1'b1;
      end else if (mode_ff == MODE_MCT) begin
         take = c_done_ff < best_complete_ff;
      end else begin
         take = c_tv_ff < best_exec_ff;
      end
      take        = take && c_ok_ff;
      nb_have     = have_best_ff || take;
      nb_machine  = take ? c_idx_ff : best_machine_ff;
      nb_complete = take ? c_done_ff : best_complete_ff;
      nb_exec     = take ? c_tv_ff : best_exec_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_CAND) begin
                  state_in = ST_CAND;
               end else if (req_last) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CAND: state_in = ST_PICK;
         ST_PICK: begin
            if (!c_last_ff) begin
               state_in = ST_IDLE;
            end else if (nb_have) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(MACHINES - 1)) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_RATIO;
         ST_RATIO: begin
            if (rres.done) begin
               state_in = res_pend_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall   = 1'b1;
      pick_close  = 1'b0;
      ratio_start = 1'b0;
      out_load    = 1'b0;
      scan_last   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_PICK:  pick_close = c_last_ff;
         ST_SCAN:  scan_last = (cnt_ff == CNT_W'(MACHINES - 1));
         ST_START: ratio_start = 1'b1;
         ST_OUT:   out_load = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   always_comb begin
      wr.en    = 1'b0;
      wr.idx   = req_machine_index;
      wr.value = req_time_value;
      if (accept && (req_op == OP_LOAD) && idx_ok) begin
         wr.en = 1'b1;
      end else if (pick_close && nb_have) begin
         wr.en    = 1'b1;
         wr.idx   = nb_machine;
         wr.value = nb_complete;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rlow_ff          <= RATIO_LOW_RESET;
         rhigh_ff         <= RATIO_HIGH_RESET;
         mode_ff          <= MODE_MCT;
         have_best_ff     <= 1'b0;
         best_machine_ff  <= '0;
         best_complete_ff <= '0;
         best_exec_ff     <= '0;
         cnt_ff           <= '0;
         res_pend_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && (csr_index == REG_RATIO_LOW)) begin
            rlow_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == REG_RATIO_HIGH)) begin
            rhigh_ff <= csr_wdata;
         end
         if (rres.done) begin
            mode_ff <= rres.mode;
         end
         if (state_ff == ST_PICK) begin
            if (c_last_ff) begin
               have_best_ff     <= 1'b0;
               best_machine_ff  <= '0;
               best_complete_ff <= '0;
               best_exec_ff     <= '0;
            end else begin
               have_best_ff     <= nb_have;
               best_machine_ff  <= nb_machine;
               best_complete_ff <= nb_complete;
               best_exec_ff     <= nb_exec;
            end
         end
         if (state_ff != ST_SCAN || scan_last) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (accept) begin
            res_pend_ff <= 1'b0;
         end else if (pick_close) begin
            res_pend_ff <= 1'b1;
         end
         rsp_valid_ff <= out_load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_idx_ff  <= req_machine_index;
         c_tv_ff   <= req_time_value;
         c_dep_ff  <= req_dep_ready;
         c_ok_ff   <= idx_ok && req_eligible;
         c_last_ff <= req_last;
      end
      if (state_ff == ST_CAND) begin
         c_done_ff <= sum_t[TIME_W] ? '1 : sum_t[TIME_W-1:0];
      end
      if (pick_close) begin
         res_machine_ff <= nb_have ? nb_machine : '0;
         res_finish_ff  <= nb_have ? nb_complete : '0;
         res_nom_ff     <= !nb_have;
      end
      if (out_load) begin
         rsp_machine_ff <= res_machine_ff;
         rsp_finish_ff  <= res_finish_ff;
         rsp_mode_ff    <= mode_ff;
         rsp_nom_ff     <= res_nom_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_assigned_machine = rsp_machine_ff;
   assign rsp_finish_time      = rsp_finish_ff;
   assign rsp_mode_after       = rsp_mode_ff;
   assign rsp_no_machine       = rsp_nom_ff;

endmodule

@@ sv/mmsm_cell.sv @@
module mmsm_cell
   import mmsm_pkg::*;
#(
   parameter int ID = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  wr_type            wr,
   input  scan_type          scan_i,
   output logic [TIME_W-1:0] ready,
   output scan_type          scan_o
);

   logic [TIME_W-1:0] ready_ff, ready_in;
   scan_type          scan_ff, scan_in;

   always_comb begin
      ready_in = ready_ff;
      if (wr.en && (32'(wr.idx) == ID)) begin
         ready_in = wr.value;
      end
   end

   always_comb begin
      scan_in.lo = (ready_ff < scan_i.lo) ? ready_ff : scan_i.lo;
      scan_in.hi = (ready_ff > scan_i.hi) ? ready_ff : scan_i.hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= '0;
      end else begin
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

   assign ready  = ready_ff;
   assign scan_o = scan_ff;

endmodule

@@ sv/mmsm_ratio.sv @@
module mmsm_ratio
   import mmsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  scan_type           span,
   input  logic [RATIO_W-1:0] ratio_low,
   input  logic [RATIO_W-1:0] ratio_high,
   input  logic               mode_cur,
   output ratio_res_type      res
);

   logic               v1_ff, v2_ff, v3_ff;
   logic [PART_W-1:0]  ph_lo_ff, ph_hi_ff, pl_lo_ff, pl_hi_ff;
   logic [PROD_W-1:0]  scaled1_ff, scaled2_ff, prod_h_ff, prod_l_ff;
   logic               zero1_ff, zero2_ff, rh_ok1_ff, rh_ok2_ff;
   logic               mode_ff, mode_in;
   logic [RATIO_W-1:0] rl_clamp;

   // split products, half of the max per multiplier
   assign rl_clamp = (ratio_low > RATIO_ONE) ? RATIO_ONE : ratio_low;

   always_ff @(posedge clock) begin
      ph_lo_ff   <= PART_W'(ratio_high) * PART_W'(span.hi[HALF_W-1:0]);
      ph_hi_ff   <= PART_W'(ratio_high) * PART_W'(span.hi[TIME_W-1:HALF_W]);
      pl_lo_ff   <= PART_W'(rl_clamp) * PART_W'(span.hi[HALF_W-1:0]);
      pl_hi_ff   <= PART_W'(rl_clamp) * PART_W'(span.hi[TIME_W-1:HALF_W]);
      scaled1_ff <= PROD_W'({span.lo, 16'd0});
      zero1_ff   <= (span.hi == '0);
      rh_ok1_ff  <= (ratio_high <= RATIO_ONE);

      prod_h_ff  <= {ph_hi_ff, {HALF_W{1'b0}}} + PROD_W'(ph_lo_ff);
      prod_l_ff  <= {pl_hi_ff, {HALF_W{1'b0}}} + PROD_W'(pl_lo_ff);
      scaled2_ff <= scaled1_ff;
      zero2_ff   <= zero1_ff;
      rh_ok2_ff  <= rh_ok1_ff;

      mode_ff    <= mode_in;
   end

   always_comb begin
      mode_in = mode_cur;
      if (!zero2_ff) begin
         if (rh_ok2_ff && (scaled2_ff >= prod_h_ff)) begin
            mode_in = MODE_MET;
         end else if (scaled2_ff <= prod_l_ff) begin
            mode_in = MODE_MCT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign res.done = v3_ff;
   assign res.mode = mode_ff;

endmodule

@@ sv/mmsm_checker.sv @@
module mmsm_checker
   import mmsm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_op,
   input logic [IDX_W-1:0]     req_machine_index,
   input logic [TIME_W-1:0]    req_time_value,
   input logic [TIME_W-1:0]    req_dep_ready,
   input logic                 req_eligible,
   input logic                 req_last,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [IDX_W-1:0]     rsp_assigned_machine,
   input logic [TIME_W-1:0]    rsp_finish_time,
   input logic                 rsp_mode_after,
   input logic                 rsp_no_machine,
   input logic                 csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [RATIO_W-1:0]   csr_wdata
);

   // held result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_assigned_machine)
         && $stable(rsp_finish_time) && $stable(rsp_mode_after) && $stable(rsp_no_machine))
      else $error("result changed while stalled");

   a_nom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_machine |-> rsp_assigned_machine == '0 && rsp_finish_time == '0)
      else $error("no machine result carries an assignment");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_CAND || req_last) |=> req_stall)
      else $error("input taken while a transaction is in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind met_mct_switching_mapper mmsm_checker u_mmsm_checker (.*);
